@@ rtl/mapi_pkg.sv @@
// Shared types and constants for the moving-average peak-index block.
// Used by every module under rtl/ but mapi_ram; depends on nothing.
package mapi_pkg;

  // Series and window limits
  localparam int MAX_LEN     = 4096;
  localparam int WINDOW_MAX  = 64;

  // Field and state widths
  localparam int SAMPLE_W    = 16;
  localparam int POS_W       = 13;
  localparam int WSIZE_W     = 7;
  localparam int CNT_W       = 7;
  localparam int SUM_W       = 23;
  localparam int PROD_W      = SUM_W + CNT_W + 1;
  localparam int HIST_AW     = $clog2(WINDOW_MAX);
  localparam int HIST_W      = SAMPLE_W + 1;

  // Floor of the mean comparison: -1.0 over a count of one
  localparam int FLOOR_SUM   = -10000;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CTR_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_POS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LO_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HI_LIMIT  = 3'd4;

  typedef struct packed {
    logic        [WSIZE_W-1:0]  win_len;
    logic        [POS_W-1:0]    ctr_first;
    logic        [POS_W-1:0]    end_pos;
    logic signed [SAMPLE_W-1:0] lo_limit;
    logic signed [SAMPLE_W-1:0] hi_limit;
  } cfg_t;

  // One classified sample on its way to the back end
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       ok;
    logic                       last;
  } q_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_UPD,
    B_MUL,
    B_CMP,
    B_FIN,
    B_DCHK,
    B_DUPD,
    B_OUT
  } back_state_t;

endpackage

@@ rtl/mapi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module mapi_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mapi_front.sv @@
// Front end: accepts samples, flags in-range ones, holds them in a short queue.
// Depends on mapi_pkg.
module mapi_front
  import mapi_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  output logic                       q_valid,
  output q_item_t                    q_item,
  input  logic                       q_pop
);

  q_item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push;
  q_item_t             push_item;

  assign in_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.sample = in_sample;
    push_item.ok     = ($signed(in_sample) >= $signed(cfg.lo_limit)) &&
                       ($signed(in_sample) <= $signed(cfg.hi_limit));
    push_item.last   = in_last;
  end

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, q_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ rtl/mapi_back.sv @@
// Back end: window sum/count over the history RAM, exact ratio compare, drain.
// Depends on mapi_pkg and mapi_ram.
module mapi_back
  import mapi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     q_valid,
  input  q_item_t                  q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  out_peak_index
);

  back_state_t                 state_r, state_nxt;
  logic        [POS_W-1:0]     pos_r, pos_nxt;
  logic        [POS_W-1:0]     iter_r, iter_nxt;
  logic        [POS_W-1:0]     mid_r, mid_nxt;
  logic signed [SUM_W-1:0]     sum_r, sum_nxt;
  logic        [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic signed [POS_W-1:0]     best_idx_r, best_idx_nxt;
  logic signed [SUM_W-1:0]     best_sum_r, best_sum_nxt;
  logic        [CNT_W-1:0]     best_cnt_r, best_cnt_nxt;
  logic signed [SUM_W-1:0]     n_r, n_nxt;
  logic        [CNT_W-1:0]     d_r, d_nxt;
  logic signed [PROD_W-1:0]    prod_a_r, prod_a_nxt;
  logic signed [PROD_W-1:0]    prod_b_r, prod_b_nxt;
  logic                        en_r, en_nxt;
  logic                        drain_r, drain_nxt;
  logic                        last_r, last_nxt;
  logic                        ok_r, ok_nxt;
  logic signed [SAMPLE_W-1:0]  samp_r, samp_nxt;
  logic signed [POS_W-1:0]     peak_r, peak_nxt;

  logic                        ram_we, ram_re;
  logic        [HIST_AW-1:0]   ram_waddr, ram_raddr;
  logic        [HIST_W-1:0]    ram_wdata, ram_rdata;

  logic        [WSIZE_W-1:0]   w;
  logic        [POS_W-1:0]     w_ext;
  logic        [POS_W-1:0]     right;
  logic                        active;
  logic                        room;
  logic        [POS_W-1:0]     cur_pos;
  logic                        drop;
  logic signed [SUM_W-1:0]     old_ext, new_ext;
  logic signed [SUM_W-1:0]     sum_drop;
  logic        [CNT_W-1:0]     cnt_drop;
  logic        [POS_W-1:0]     drain_end;

  mapi_ram #(
    .WIDTH (HIST_W),
    .DEPTH (WINDOW_MAX)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign w         = cfg.win_len;
  assign w_ext     = POS_W'(w);
  assign right     = POS_W'(w >> 1);
  assign active    = (w != '0) && (w <= WSIZE_W'(WINDOW_MAX));
  assign room      = (pos_r < POS_W'(MAX_LEN));
  assign cur_pos   = (state_r == B_DUPD) ? iter_r : pos_r;
  assign drop      = (cur_pos >= w_ext) && ram_rdata[SAMPLE_W];
  assign old_ext   = {{(SUM_W-SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata[SAMPLE_W-1:0]};
  assign new_ext   = {{(SUM_W-SAMPLE_W){samp_r[SAMPLE_W-1]}}, samp_r};
  assign sum_drop  = drop ? sum_r - old_ext : sum_r;
  assign cnt_drop  = (drop && cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
  assign drain_end = pos_r + right;

  assign out_valid      = (state_r == B_OUT);
  assign out_peak_index = peak_r;

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    iter_nxt     = iter_r;
    mid_nxt      = mid_r;
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    best_idx_nxt = best_idx_r;
    best_sum_nxt = best_sum_r;
    best_cnt_nxt = best_cnt_r;
    n_nxt        = n_r;
    d_nxt        = d_r;
    prod_a_nxt   = prod_a_r;
    prod_b_nxt   = prod_b_r;
    en_nxt       = en_r;
    drain_nxt    = drain_r;
    last_nxt     = last_r;
    ok_nxt       = ok_r;
    samp_nxt     = samp_r;
    peak_nxt     = peak_r;
    q_pop        = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    ram_we       = 1'b0;
    ram_waddr    = pos_r[HIST_AW-1:0];
    ram_wdata    = {ok_r, samp_r};

    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          samp_nxt = q_item.sample;
          ok_nxt   = q_item.ok;
          last_nxt = q_item.last;
          if (room && active) begin
            // fetch the sample leaving the window
            ram_re    = 1'b1;
            ram_raddr = HIST_AW'(pos_r - w_ext);
            state_nxt = B_UPD;
          end else begin
            if (room) begin
              pos_nxt = pos_r + 1'b1;
            end
            state_nxt = q_item.last ? B_FIN : B_IDLE;
          end
        end
      end

      B_UPD: begin
        ram_we  = 1'b1;
        sum_nxt = ok_r ? sum_drop + new_ext : sum_drop;
        cnt_nxt = cnt_drop + CNT_W'(ok_r);
        pos_nxt = pos_r + 1'b1;
        mid_nxt = pos_r - right;
        if (pos_r >= right) begin
          state_nxt = B_MUL;
        end else begin
          state_nxt = last_r ? B_FIN : B_IDLE;
        end
      end

      B_MUL: begin
        n_nxt      = (cnt_r != '0) ? sum_r : '0;
        d_nxt      = (cnt_r != '0) ? cnt_r : CNT_W'(1);
        prod_a_nxt = PROD_W'(n_nxt) * $signed(PROD_W'({1'b0, best_cnt_r}));
        prod_b_nxt = PROD_W'(best_sum_r) * $signed(PROD_W'({1'b0, d_nxt}));
        en_nxt     = (mid_r >= cfg.ctr_first) && (mid_r < cfg.end_pos);
        state_nxt  = B_CMP;
      end

      B_CMP: begin
        if (en_r && (prod_a_r > prod_b_r)) begin
          best_sum_nxt = n_r;
          best_cnt_nxt = d_r;
          best_idx_nxt = mid_r;
        end
        if (drain_r) begin
          iter_nxt  = iter_r + 1'b1;
          state_nxt = B_DCHK;
        end else begin
          state_nxt = last_r ? B_FIN : B_IDLE;
        end
      end

      B_FIN: begin
        if (active && (w_ext <= pos_r)) begin
          iter_nxt  = pos_r;
          drain_nxt = 1'b1;
          state_nxt = B_DCHK;
        end else begin
          peak_nxt  = '0;
          state_nxt = B_OUT;
        end
      end

      B_DCHK: begin
        if (iter_r < drain_end) begin
          ram_re    = 1'b1;
          ram_raddr = HIST_AW'(iter_r - w_ext);
          state_nxt = B_DUPD;
        end else begin
          peak_nxt  = best_idx_r;
          state_nxt = B_OUT;
        end
      end

      B_DUPD: begin
        sum_nxt   = sum_drop;
        cnt_nxt   = cnt_drop;
        mid_nxt   = iter_r - right;
        state_nxt = B_MUL;
      end

      B_OUT: begin
        // restart the series state once the result is taken
        if (out_ready) begin
          pos_nxt      = '0;
          sum_nxt      = '0;
          cnt_nxt      = '0;
          best_idx_nxt = '1;
          best_sum_nxt = SUM_W'(FLOOR_SUM);
          best_cnt_nxt = CNT_W'(1);
          drain_nxt    = 1'b0;
          state_nxt    = B_IDLE;
        end
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      pos_r      <= '0;
      sum_r      <= '0;
      cnt_r      <= '0;
      best_idx_r <= '1;
      best_sum_r <= SUM_W'(FLOOR_SUM);
      best_cnt_r <= CNT_W'(1);
      drain_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      cnt_r      <= cnt_nxt;
      best_idx_r <= best_idx_nxt;
      best_sum_r <= best_sum_nxt;
      best_cnt_r <= best_cnt_nxt;
      drain_r    <= drain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iter_r   <= iter_nxt;
    mid_r    <= mid_nxt;
    n_r      <= n_nxt;
    d_r      <= d_nxt;
    prod_a_r <= prod_a_nxt;
    prod_b_r <= prod_b_nxt;
    en_r     <= en_nxt;
    last_r   <= last_nxt;
    ok_r     <= ok_nxt;
    samp_r   <= samp_nxt;
    peak_r   <= peak_nxt;
  end

  a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT && out_ready) |=> (pos_r == '0 && cnt_r == '0 && !drain_r))
    else $error("series state not cleared after result");

  a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == B_UPD && $past(state_r) == B_IDLE))
    else $error("history written outside sample update");

endmodule

@@ rtl/moving_average_peak_index_top.sv @@
// Top level of the centered moving-average peak-index block.
// Holds the configuration registers; depends on mapi_pkg, mapi_front, mapi_back.
//
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_ready   in_sample[15:0] signed, in_last
//  out_     output     out_valid/out_ready out_peak_index[12:0] signed
//  cfg_     input      cfg_we              cfg_index[2:0], cfg_wdata[15:0]
//
// In the back end a sample passes only B_IDLE when the window is inactive or the
// series is full, also B_UPD otherwise, and B_MUL and B_CMP when its window center
// is judged (registered history RAM read, then multiply and compare stages). The
// drain after a last sample runs B_FIN, and B_DCHK, B_DUPD, B_MUL, B_CMP per center.
// A 4-deep queue takes samples until full while the back end works or a result waits.
// Reset is synchronous, active low; the history RAM holds no reset state.
module moving_average_peak_index_top
  import mapi_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [POS_W-1:0]     out_peak_index,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt;
  logic    q_valid;
  logic    q_pop;
  q_item_t q_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WIN_LEN:   cfg_nxt.win_len   = cfg_wdata[WSIZE_W-1:0];
        CFG_CTR_FIRST: cfg_nxt.ctr_first = cfg_wdata[POS_W-1:0];
        CFG_END_POS:   cfg_nxt.end_pos   = cfg_wdata[POS_W-1:0];
        CFG_LO_LIMIT:  cfg_nxt.lo_limit  = $signed(cfg_wdata[SAMPLE_W-1:0]);
        CFG_HI_LIMIT:  cfg_nxt.hi_limit  = $signed(cfg_wdata[SAMPLE_W-1:0]);
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.win_len   <= WSIZE_W'(3);
      cfg_r.ctr_first <= '0;
      cfg_r.end_pos   <= POS_W'(MAX_LEN);
      cfg_r.lo_limit  <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      cfg_r.hi_limit  <= {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mapi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .in_last   (in_last),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  mapi_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_peak_index (out_peak_index)
  );

endmodule

@@ verif/tb_moving_average_peak_index_top.sv @@
// Self-checking testbench for moving_average_peak_index_top: a directed table and
// random series under several idle and stall mixes, scored against an in-bench
// predictor or typed table peaks. Depends on mapi_pkg and the RTL under rtl/.
module tb_moving_average_peak_index_top;
  import mapi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int GROUP_ITEMS    = 26;

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                        clk;
  logic                        rst_n          = 1'b0;
  logic                        in_valid       = 1'b0;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  in_sample      = '0;
  logic                        in_last        = 1'b0;
  logic                        out_valid;
  logic                        out_ready      = 1'b0;
  logic signed [POS_W-1:0]     out_peak_index;
  logic                        cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index      = '0;
  logic [CFG_DATA_W-1:0]       cfg_wdata      = '0;

  moving_average_peak_index_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  cfg_t                        regs;
  logic signed [SAMPLE_W-1:0]  hist_val [WINDOW_MAX];
  bit                          hist_ok  [WINDOW_MAX];
  longint                      run_sum, run_cnt, best_sum, best_cnt, best_idx;
  int unsigned                 series_pos;

  logic signed [POS_W-1:0]     peak_q [$];
  logic signed [POS_W-1:0]     want;
  int                          mismatches = 0;
  int                          quiet_cycles = 0;
  int                          send_idle_pct = 0;
  int                          recv_stall_pct = 0;

  function automatic void restart_series();
    run_sum    = 0;
    run_cnt    = 0;
    series_pos = 0;
    best_idx   = -1;
    best_sum   = FLOOR_SUM;
    best_cnt   = 1;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_WIN_LEN:   regs.win_len   = data[WSIZE_W-1:0];
      CFG_CTR_FIRST: regs.ctr_first = data[POS_W-1:0];
      CFG_END_POS:   regs.end_pos   = data[POS_W-1:0];
      CFG_LO_LIMIT:  regs.lo_limit  = data;
      CFG_HI_LIMIT:  regs.hi_limit  = data;
      default: ;
    endcase
  endfunction

  function automatic void retire_sample(input int unsigned p);
    int unsigned slot;
    slot = p % WINDOW_MAX;
    if (hist_ok[slot]) begin
      run_sum -= hist_val[slot];
      if (run_cnt > 0) run_cnt--;
    end
  endfunction

  // Compare means as cross products so no division is needed
  function automatic void judge_center(input int unsigned mid);
    longint n, d;
    if (mid < regs.ctr_first || mid >= regs.end_pos) return;
    n = (run_cnt != 0) ? run_sum : 0;
    d = (run_cnt != 0) ? run_cnt : 1;
    if (n * best_cnt > best_sum * d) begin
      best_sum = n;
      best_cnt = d;
      best_idx = mid;
    end
  endfunction

  function automatic void advance_series(input logic signed [SAMPLE_W-1:0] s,
                                         input logic lst, output bit done,
                                         output logic signed [POS_W-1:0] peak);
    int unsigned w, right, span, i;
    bit active, ok;
    w      = regs.win_len;
    active = (w >= 1) && (w <= WINDOW_MAX);
    right  = active ? (w - 1) - (w - 1) / 2 : 0;
    done   = lst;
    peak   = '0;
    if (series_pos < MAX_LEN) begin
      if (active) begin
        ok = (s >= $signed(regs.lo_limit)) && (s <= $signed(regs.hi_limit));
        if (series_pos >= w) retire_sample(series_pos - w);
        hist_val[series_pos % WINDOW_MAX] = s;
        hist_ok[series_pos % WINDOW_MAX]  = ok;
        if (ok) begin
          run_sum += s;
          run_cnt++;
        end
        if (series_pos >= right) judge_center(series_pos - right);
      end
      series_pos++;
    end
    if (!lst) return;
    span = series_pos;
    // Drain: slide the window past the end so the trailing centers are judged
    if (active && w <= span) begin
      for (i = span; i < span + right; i++) begin
        if (i >= w) retire_sample(i - w);
        judge_center(i - right);
      end
      peak = POS_W'(best_idx);
    end
    restart_series();
  endfunction

  // ---------------------------------------------------------------- drivers
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_item(input logic signed [SAMPLE_W-1:0] s, input logic lst,
                           input bit typed = 1'b0,
                           input logic signed [POS_W-1:0] typed_peak = '0);
    bit done;
    logic signed [POS_W-1:0] peak;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid  <= 1'b0;
      in_sample <= SAMPLE_W'($urandom);
      in_last   <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    in_last   <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_series(s, lst, done, peak);
    if (done) peak_q.push_back(typed ? typed_peak : peak);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    apply_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the input until every result is in and the back end has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (peak_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 50) return SAMPLE_W'($urandom);
    if (r < 85) return SAMPLE_W'(int'($urandom_range(24000)) - 12000);
    return SAMPLE_W'(int'($urandom_range(40)) - 10020);   // hug the -1.0 floor
  endfunction

  function automatic int pick_len(input int w);
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(12, 1);
    if (r < 70 && w >= 1 && w <= WINDOW_MAX) return w - 1 + $urandom_range(3) + (w == 1);
    if (r < 95) return $urandom_range(40, 13);
    return $urandom_range(80, 41);
  endfunction

  task automatic random_setup();
    int r, w, first, bound, lo, hi;
    r = $urandom_range(99);
    if (r < 8)       w = 0;
    else if (r < 14) w = WINDOW_MAX;
    else if (r < 18) w = $urandom_range(127, WINDOW_MAX + 1);
    else if (r < 40) w = $urandom_range(WINDOW_MAX - 1, 10);
    else             w = $urandom_range(9, 1);
    r = $urandom_range(99);
    if (r < 60) begin
      first = 0;
      bound = MAX_LEN;
    end else if (r < 80) begin
      first = $urandom_range(20);
      bound = first + $urandom_range(30);
    end else if (r < 90) begin
      first = $urandom_range(MAX_LEN, 1);
      bound = $urandom_range(first - 1);
    end else begin
      first = $urandom_range(1) ? MAX_LEN : 0;
      bound = $urandom_range(1) ? MAX_LEN : 0;
    end
    r = $urandom_range(99);
    if (r < 50) begin
      lo = -32768;
      hi = 32767;
    end else if (r < 80) begin
      lo = -int'($urandom_range(15000));
      hi = $urandom_range(15000);
    end else if (r < 90) begin
      lo = $urandom_range(20000, 1);
      hi = lo - 1 - int'($urandom_range(20000));
    end else begin
      lo = int'($urandom_range(65535)) - 32768;
      hi = lo;
    end
    write_reg(CFG_WIN_LEN,   CFG_DATA_W'(w));
    write_reg(CFG_CTR_FIRST, CFG_DATA_W'(first));
    write_reg(CFG_END_POS,   CFG_DATA_W'(bound));
    write_reg(CFG_LO_LIMIT,  CFG_DATA_W'(lo));
    write_reg(CFG_HI_LIMIT,  CFG_DATA_W'(hi));
  endtask

  // ---------------------------------------------------------------- directed table
  typedef enum logic [1:0] {STEP_ITEM, STEP_REG, STEP_HOLD} step_kind_t;

  typedef struct {
    step_kind_t              kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;   // sample for items, value for register writes
    logic                    last;
    bit                      typed;
    logic signed [POS_W-1:0] peak;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic void plan_item(input logic [CFG_DATA_W-1:0] s, input logic lst,
                                    input bit typed = 1'b0,
                                    input logic signed [POS_W-1:0] peak = '0);
    plan.push_back('{STEP_ITEM, '0, s, lst, typed, peak});
  endfunction

  function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
    plan.push_back('{STEP_REG, idx, data, 1'b0, 1'b0, '0});
  endfunction

  function automatic void build_plan();
    // Reset settings: window of three, whole range eligible
    plan_item(100, 0);
    plan_item(200, 1, 1'b1, 0);                 // series shorter than window
    plan_item(-32768, 1, 1'b1, 0);
    plan_item(-32768, 0);
    plan_item(-32768, 0);
    plan_item(-32768, 1, 1'b1, -1);             // nothing beats the floor
    plan_item(32767, 0);
    plan_item(-1, 0);
    plan_item(0, 1);
    plan_reg(CFG_WIN_LEN, 0);                   // zero-length window
    plan_item(5, 0);
    plan_item(5, 1, 1'b1, 0);
    plan_reg(CFG_WIN_LEN, 127);                 // wider than the history
    plan_item(7, 1, 1'b1, 0);
    plan_reg(CFG_WIN_LEN, 1);
    plan_item(5, 0);
    plan_item(7, 0);
    plan_item(3, 1, 1'b1, 1);
    plan_reg(CFG_CTR_FIRST, 2);                 // empty eligible range
    plan_reg(CFG_END_POS, 2);
    plan_item(9, 0);
    plan_item(9, 1, 1'b1, -1);
    plan_reg(CFG_CTR_FIRST, 0);
    plan_reg(CFG_END_POS, MAX_LEN);
    plan_reg(CFG_LO_LIMIT, 32767);
    plan_reg(CFG_HI_LIMIT, 32767);
    plan_item(-5, 0);
    plan_item(32767, 1, 1'b1, 1);               // empty window scores 0, then the max
    plan_reg(CFG_LO_LIMIT, -32768);
    plan_reg(CFG_HI_LIMIT, 32767);
    plan_reg(CFG_WIN_LEN, WINDOW_MAX);
    plan_reg(CFG_SPARE, 16'hFFFF);
    plan_item(1, 1, 1'b1, 0);
    // Range limits changed partway through a series
    plan_reg(CFG_WIN_LEN, 5);
    plan_reg(CFG_CTR_FIRST, 1);
    plan_reg(CFG_END_POS, 3);
    plan_item(1000, 0);
    plan_item(-1000, 0);
    plan_item(2000, 0);
    plan.push_back('{STEP_HOLD, '0, '0, 1'b0, 1'b0, '0});
    plan_reg(CFG_LO_LIMIT, 0);
    plan_reg(CFG_HI_LIMIT, 1500);
    plan_item(3000, 0);
    plan_item(-20000, 0);
    plan_item(500, 1);
  endfunction

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (peak_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got peak_index %0d",
                 $time, out_peak_index);
        mismatches++;
      end else begin
        want = peak_q.pop_front();
        if (out_peak_index !== want) begin
          $display("%0t: peak_index expected %0d, got %0d", $time, want, out_peak_index);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("** moving_average_peak_index_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  int send_mix [4] = '{0, 83, 0, 12};
  int recv_mix [4] = '{0, 0, 83, 12};

  initial begin : stimulus
    step_kind_t prev;
    int mode, grp, sent, len, k;
    regs.win_len   = 3;
    regs.ctr_first = 0;
    regs.end_pos   = MAX_LEN;
    regs.lo_limit  = -32768;
    regs.hi_limit  = 32767;
    for (k = 0; k < WINDOW_MAX; k++) begin
      hist_val[k] = '0;
      hist_ok[k]  = 1'b0;
    end
    restart_series();
    build_plan();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    prev = STEP_HOLD;
    foreach (plan[k]) begin
      case (plan[k].kind)
        STEP_ITEM: send_item(plan[k].data, plan[k].last, plan[k].typed, plan[k].peak);
        STEP_REG: begin
          if (prev == STEP_ITEM) settle();
          write_reg(plan[k].idx, plan[k].data);
        end
        default: settle();
      endcase
      prev = plan[k].kind;
    end

    for (mode = 0; mode < 4; mode++) begin
      send_idle_pct  = send_mix[mode];
      recv_stall_pct = recv_mix[mode];
      for (grp = 0; grp < 3; grp++) begin
        settle();
        random_setup();
        sent = 0;
        while (sent < GROUP_ITEMS) begin
          len = pick_len(regs.win_len);
          for (k = 0; k < len; k++) send_item(pick_sample(), k == len - 1);
          sent += len;
        end
      end
    end

    settle();
    if (mismatches == 0)
      $display("** moving_average_peak_index_top: PASSED **");
    else
      $display("** moving_average_peak_index_top: FAILED **");
    $finish;
  end

endmodule
